FILE: hdl/cdad_pkg.sv
package cdad_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned ADD_W   = 15;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 24;

    // The running year may run one bit past the field before it is truncated.
    localparam int unsigned YCNT_W  = YEAR_W + 1;
    localparam int unsigned REM_W   = 16;
    localparam int unsigned CENT_W  = 8;
    localparam int unsigned R100_W  = 7;

    // year / 100 == (year * 5243) >> 19 for every year below 43699.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIX  = 5'b00010,
        S_SUM  = 5'b00100,
        S_YEAR = 5'b01000,
        S_MON  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic fix;
        logic sum_step;
        logic year_step;
        logic mon_reset;
        logic mon_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sum_done;
        logic year_done;
        logic mon_done;
    } t_stat;

    function automatic logic f_leap(input logic [R100_W-1:0] r100,
                                    input logic [CENT_W-1:0] cent);
        logic leap;
        if (r100 != '0) begin
            leap = (r100[1:0] == 2'd0);
        end else begin
            leap = (cent[1:0] == 2'd0);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] f_year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

FILE: hdl/calendar_date_add_days_top.sv
// Gregorian date plus a day count.
// The slave stream carries one beat per request: start date and days to add.
// The master stream returns one beat per request with the resulting date.
// A request is taken only while the block is idle; o_s_axis_tready is low
// from acceptance until the result is moved into the output register.
// From acceptance the request passes through S_FIX and then a walk that takes
// one step per cycle: first the earlier months (start_month - 1 of them, none
// for month zero), then whole years, then whole months. The result then moves
// into the output register.
// The next request can be taken in the cycle after a result enters the output
// register. The output register lets that request be accepted while the
// previous result still waits on i_m_axis_tready. If a result is finished
// while the output register is still held by a stalled receiver, the block
// waits.
// i_rst_n is synchronous and active low; it empties the output register and
// returns the controller to idle. There is no other state to clear.
module calendar_date_add_days_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[37:23]
    input  logic [cdad_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // result_day[4:0], result_month[8:5], result_year[22:9]
    output logic [cdad_pkg::OUT_W-1:0]    o_m_axis_tdata
);
    import cdad_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cdad_dp u_dp (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_data (i_s_axis_tdata),
        .o_stat (w_stat),
        .o_data (o_m_axis_tdata)
    );

    // A load command is issued exactly on an accepted input beat.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load == (i_s_axis_tvalid && o_s_axis_tready)))
        else $error("load command does not match input beat");

    // The controller never issues two datapath commands at once.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    // A result never overwrites a beat the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten");

    // A loaded result is offered in the next cycle.
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

FILE: hdl/cdad_ctrl.sv
module cdad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cdad_pkg::t_stat i_stat,
    output cdad_pkg::t_cmd  o_cmd
);
    import cdad_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (i_stat.sum_done) begin
                    n_state = S_YEAR;
                end else begin
                    o_cmd.sum_step = 1'b1;
                end
            end
            S_YEAR: begin
                if (i_stat.year_done) begin
                    o_cmd.mon_reset = 1'b1;
                    n_state         = S_MON;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MON: begin
                if (i_stat.mon_done) begin
                    // Hold the finished result until the output register is free.
                    if (w_out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.mon_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/cdad_dp.sv
module cdad_dp (
    input  logic                         i_clk,
    input  cdad_pkg::t_cmd               i_cmd,
    input  logic [cdad_pkg::IN_W-1:0]    i_data,
    output cdad_pkg::t_stat              o_stat,
    output logic [cdad_pkg::OUT_W-1:0]   o_data
);
    import cdad_pkg::*;

    logic [DAY_W-1:0]   w_day;
    logic [MONTH_W-1:0] w_month;
    logic [YEAR_W-1:0]  w_year;
    logic [ADD_W-1:0]   w_add;
    logic [PROD_W-1:0]  w_prod;

    logic [MONTH_W-1:0] r_month;
    logic [YCNT_W-1:0]  r_year;
    logic [CENT_W-1:0]  r_cent;
    logic [R100_W-1:0]  r_r100;
    logic [MONTH_W-1:0] r_m;
    logic [REM_W-1:0]   r_rem;
    logic [OUT_W-1:0]   r_out;

    logic               w_leap;
    logic [DAY_W-1:0]   w_mlen;
    logic [REM_W-1:0]   w_mlen_x;
    logic [REM_W-1:0]   w_ylen_x;
    logic [YCNT_W-1:0]  w_cent100;

    assign w_day   = i_data[DAY_W-1:0];
    assign w_month = i_data[DAY_W +: MONTH_W];
    assign w_year  = i_data[DAY_W+MONTH_W +: YEAR_W];
    assign w_add   = i_data[DAY_W+MONTH_W+YEAR_W +: ADD_W];

    assign w_prod    = PROD_W'(w_year) * PROD_W'(RECIP_100);
    assign w_cent100 = (YCNT_W'(r_cent) << 6) + (YCNT_W'(r_cent) << 5)
                     + (YCNT_W'(r_cent) << 2);

    assign w_leap   = f_leap(r_r100, r_cent);
    assign w_mlen   = f_month_len(r_m, w_leap);
    assign w_mlen_x = REM_W'(w_mlen);
    assign w_ylen_x = REM_W'(f_year_len(w_leap));

    assign o_stat.sum_done  = !(r_m < r_month);
    assign o_stat.year_done = (w_ylen_x >= r_rem);
    assign o_stat.mon_done  = (w_mlen_x >= r_rem) || (r_m >= DECEMBER);

    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_month <= w_month;
            r_year  <= YCNT_W'(w_year);
            r_cent  <= w_prod[RECIP_SHIFT +: CENT_W];
            r_m     <= MONTH_W'(1);
            r_rem   <= REM_W'(w_day) + REM_W'(w_add);
        end
        if (i_cmd.fix) begin
            r_r100 <= R100_W'(r_year - w_cent100);
        end
        if (i_cmd.sum_step || i_cmd.mon_step) begin
            r_rem <= r_rem + (i_cmd.sum_step ? w_mlen_x : REM_W'(0))
                           - (i_cmd.mon_step ? w_mlen_x : REM_W'(0));
            r_m   <= r_m + MONTH_W'(1);
        end
        if (i_cmd.year_step) begin
            r_rem  <= r_rem - w_ylen_x;
            r_year <= r_year + YCNT_W'(1);
            // Keep year split into century and year-in-century for the leap test.
            if (r_r100 == R100_W'(99)) begin
                r_r100 <= '0;
                r_cent <= r_cent + CENT_W'(1);
            end else begin
                r_r100 <= r_r100 + R100_W'(1);
            end
        end
        if (i_cmd.mon_reset) begin
            r_m <= MONTH_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out <= {1'b0, r_year[YEAR_W-1:0], r_m, r_rem[DAY_W-1:0]};
        end
    end

endmodule
